// ===== rtl/colorkey_framebuffer_upscaler_defines.svh =====
// Assertion macros used by the frame store checker.
`ifndef COLORKEY_FRAMEBUFFER_UPSCALER_DEFINES_SVH
`define COLORKEY_FRAMEBUFFER_UPSCALER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CFBU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CFBU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cfbu_pkg.sv =====
// Shared constants and opcode type for the upscaling frame store.
package cfbu_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_SCALE  = 8;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int PIXEL_W = 24;

  localparam logic [8:0] MAX_WIDTH_V  = 9'(MAX_WIDTH);
  localparam logic [8:0] MAX_HEIGHT_V = 9'(MAX_HEIGHT);
  localparam logic [3:0] MAX_SCALE_V  = 4'(MAX_SCALE);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SCAN  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_SCALE_X      = 2'd2,
    REG_SCALE_Y      = 2'd3
  } reg_idx_t;

endpackage

// ===== rtl/cfbu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cfbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/colorkey_framebuffer_upscaler.sv =====
// Top level: RGB frame store with integer nearest-neighbor upscaling scan-out.
//
//   channel | direction | handshake          | payload
//   in_     | request   | in_valid/in_stall  | operation, row, column, red/green/blue_in
//   out_    | result    | out_valid/out_stall| red/green/blue_out, line_end, frame_end
//   cfg_    | write     | cfg_wr_en          | cfg_index, cfg_wdata
//
// One request per cycle while in_stall is low; a read or scan result appears
// in the cycle after accept, set by the registered read data of the pixel RAM port.
// Writes, keyed writes and unused opcodes produce no result.
// in_stall rises only while a result is held by out_stall.
// rst_n clears scan counters and out_valid, presets config registers; no clearing pass.
module colorkey_framebuffer_upscaler
  import cfbu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [7:0]        in_row,
  input  logic [7:0]        in_column,
  input  logic signed [8:0] in_red_in,
  input  logic signed [8:0] in_green_in,
  input  logic signed [8:0] in_blue_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_red_out,
  output logic [7:0]        out_green_out,
  output logic [7:0]        out_blue_out,
  output logic              out_line_end,
  output logic              out_frame_end,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_wdata
);

  function automatic logic [8:0] clamp_dim(input logic [8:0] v, input logic [8:0] hi);
    if (v == 9'd0) return 9'd1;
    if (v > hi)    return hi;
    return v;
  endfunction

  function automatic logic [3:0] clamp_scale(input logic [3:0] v);
    if (v == 4'd0)        return 4'd1;
    if (v > MAX_SCALE_V)  return MAX_SCALE_V;
    return v;
  endfunction

  logic [8:0] frame_width_r, frame_height_r;
  logic [3:0] scale_x_r, scale_y_r;
  logic [8:0] w_eff, h_eff;
  logic [3:0] sx_eff, sy_eff;

  logic [ROW_W-1:0] scan_row_r, scan_row_nxt, row_n;
  logic [COL_W-1:0] scan_col_r, scan_col_nxt, col_n;
  logic [2:0]       scan_rrep_r, scan_rrep_nxt, rrep_n;
  logic [2:0]       scan_crep_r, scan_crep_nxt, crep_n;
  logic             col_last, crep_last, row_last, rrep_last;
  logic             scan_le, scan_fe;

  logic             p1_valid_r, p1_valid_nxt;
  logic             p1_zero_r, p1_zero_nxt;
  logic             p1_le_r, p1_le_nxt;
  logic             p1_fe_r, p1_fe_nxt;

  logic             in_acc, is_write, is_read, is_scan;
  logic             key_hit, addr_in_range;
  logic             ram_we, ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [PIXEL_W-1:0] ram_wdata, ram_rdata_r;

  assign w_eff  = clamp_dim(frame_width_r, MAX_WIDTH_V);
  assign h_eff  = clamp_dim(frame_height_r, MAX_HEIGHT_V);
  assign sx_eff = clamp_scale(scale_x_r);
  assign sy_eff = clamp_scale(scale_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= MAX_WIDTH_V;
      frame_height_r <= MAX_HEIGHT_V;
      scale_x_r      <= 4'd1;
      scale_y_r      <= 4'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        REG_SCALE_X:      scale_x_r      <= cfg_wdata[3:0];
        REG_SCALE_Y:      scale_y_r      <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign in_stall = p1_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign is_write = in_operation == OP_WRITE;
  assign is_read  = in_operation == OP_READ;
  assign is_scan  = in_operation == OP_SCAN;

  assign key_hit       = (&in_red_in) & (&in_green_in) & (&in_blue_in);
  assign addr_in_range = ({1'b0, in_row} < h_eff) && ({1'b0, in_column} < w_eff);

  // scan position, restarted where a counter lies beyond a shrunk frame or scale
  always_comb begin
    row_n  = ({1'b0, scan_row_r} >= h_eff) ? '0 : scan_row_r;
    col_n  = ({1'b0, scan_col_r} >= w_eff) ? '0 : scan_col_r;
    rrep_n = ({1'b0, scan_rrep_r} >= sy_eff) ? '0 : scan_rrep_r;
    crep_n = ({1'b0, scan_crep_r} >= sx_eff) ? '0 : scan_crep_r;

    col_last  = {1'b0, col_n} == (w_eff - 9'd1);
    crep_last = {1'b0, crep_n} == (sx_eff - 4'd1);
    row_last  = {1'b0, row_n} == (h_eff - 9'd1);
    rrep_last = {1'b0, rrep_n} == (sy_eff - 4'd1);
    scan_le   = col_last & crep_last;
    scan_fe   = scan_le & row_last & rrep_last;

    scan_row_nxt  = row_n;
    scan_col_nxt  = col_n;
    scan_rrep_nxt = rrep_n;
    scan_crep_nxt = crep_n + 3'd1;
    if (crep_last) begin
      scan_crep_nxt = '0;
      scan_col_nxt  = col_n + 1'b1;
      if (col_last) begin
        scan_col_nxt  = '0;
        scan_rrep_nxt = rrep_n + 3'd1;
        if (rrep_last) begin
          scan_rrep_nxt = '0;
          scan_row_nxt  = row_last ? '0 : row_n + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_row_r  <= '0;
      scan_col_r  <= '0;
      scan_rrep_r <= '0;
      scan_crep_r <= '0;
    end else if (in_acc && is_scan) begin
      scan_row_r  <= scan_row_nxt;
      scan_col_r  <= scan_col_nxt;
      scan_rrep_r <= scan_rrep_nxt;
      scan_crep_r <= scan_crep_nxt;
    end
  end

  assign ram_we    = in_acc & is_write & ~key_hit & addr_in_range;
  assign ram_wdata = {in_red_in[7:0], in_green_in[7:0], in_blue_in[7:0]};
  assign ram_re    = in_acc & (is_read | is_scan);
  assign ram_raddr = is_scan ? {row_n, col_n} : {in_row, in_column};

  cfbu_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(DEPTH)
  ) u_pixel_ram (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   ({in_row, in_column}),
    .wr_data   (ram_wdata),
    .rd_en     (ram_re),
    .rd_addr   (ram_raddr),
    .rd_data_r (ram_rdata_r)
  );

  // result stage: RAM read register holds the pixel, flags ride alongside
  always_comb begin
    p1_valid_nxt = p1_valid_r & out_stall;
    p1_zero_nxt  = p1_zero_r;
    p1_le_nxt    = p1_le_r;
    p1_fe_nxt    = p1_fe_r;
    if (ram_re) begin
      p1_valid_nxt = 1'b1;
      p1_zero_nxt  = is_read & ~addr_in_range;
      p1_le_nxt    = is_scan & scan_le;
      p1_fe_nxt    = is_scan & scan_fe;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= p1_valid_nxt;
    end
    p1_zero_r <= p1_zero_nxt;
    p1_le_r   <= p1_le_nxt;
    p1_fe_r   <= p1_fe_nxt;
  end

  assign out_valid     = p1_valid_r;
  assign out_red_out   = p1_zero_r ? 8'd0 : ram_rdata_r[23:16];
  assign out_green_out = p1_zero_r ? 8'd0 : ram_rdata_r[15:8];
  assign out_blue_out  = p1_zero_r ? 8'd0 : ram_rdata_r[7:0];
  assign out_line_end  = p1_le_r;
  assign out_frame_end = p1_fe_r;

endmodule

// ===== rtl/cfbu_checker.sv =====
// Port-level checker for the upscaling frame store, bound to the top level.
`include "colorkey_framebuffer_upscaler_defines.svh"

module cfbu_checker
  import cfbu_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_operation,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_line_end,
  input logic       out_frame_end
);

  logic in_acc, acc_write, acc_read, acc_result;
  assign in_acc     = in_valid & ~in_stall;
  assign acc_write  = in_acc & (in_operation == OP_WRITE);
  assign acc_read   = in_acc & (in_operation == OP_READ);
  assign acc_result = in_acc & ((in_operation == OP_READ) | (in_operation == OP_SCAN));

  `CFBU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")
  `CFBU_ASSERT_SAME(a_fe_le, out_valid && out_frame_end, out_line_end, "frame end w/o line end")
  `CFBU_ASSERT_NEXT(a_write_silent, acc_write, !out_valid, "write request produced a result")
  `CFBU_ASSERT_NEXT(a_result_due, acc_result, out_valid, "read or scan request gave no result")
  `CFBU_ASSERT_NEXT(a_read_flags, acc_read, !(out_line_end | out_frame_end), "read flags set")

endmodule

bind colorkey_framebuffer_upscaler cfbu_checker u_cfbu_checker (.*);
